// ===== hdl/imhp_pkg.sv =====
// Shared types and constants for the indexed min-heap pairs unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package imhp_pkg;

   localparam int MAX_SIDE = 16;
   localparam int PAIRS    = MAX_SIDE * MAX_SIDE;
   localparam int SIDE_W   = 5;
   localparam int COORD_W  = 4;
   localparam int PAIR_W   = $clog2(PAIRS);
   localparam int SLOT_W   = PAIR_W + 1;
   localparam int DIST_W   = 32;

   localparam logic [DIST_W-1:0] INFINITY = {DIST_W{1'b1}};
   localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_BUILD  = 2'd1,
      CMD_CHANGE = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_IDX_WAIT,
      ST_CHG_CMP,
      ST_REM_W1,
      ST_REM_W2,
      ST_BUILD_NEXT,
      ST_BUILD_LOAD,
      ST_SK_TEST,
      ST_SK_CMP1,
      ST_SK_CMP2,
      ST_RS_TEST,
      ST_RS_CMP,
      ST_FINISH,
      ST_DONE
   } state_type;

   // One heap slot: distance and the pair it belongs to
   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [PAIR_W-1:0] pair;
   } slot_entry_type;

   // Result of the shared magnitude compare
   typedef struct packed {
      logic gt;
      logic lt;
   } cmp_result_type;

endpackage
`default_nettype wire

// ===== hdl/indexed_min_heap_pairs_unit.sv =====
// Indexed min-heap pairs unit: sequencer over slot memory, index memory and comparator.
// Change and remove sift the entry down or up level by level; build sifts all n*n slots down, last first.
// One transaction at a time: next request can be taken in the same cycle the response is raised.
// Synchronous active-high reset: heap empty, matrix_size 16; memories are not cleared.
// Depends on imhp_pkg, imhp_compare, imhp_slot_ram, imhp_index_ram.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_pairs_unit
   import imhp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [SIDE_W-1:0]  csr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_command,
   input  wire logic [COORD_W-1:0] req_row,
   input  wire logic [COORD_W-1:0] req_column,
   input  wire logic [DIST_W-1:0]  req_distance,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [DIST_W-1:0]       rsp_min_distance,
   output logic [COORD_W-1:0]      rsp_min_row,
   output logic [COORD_W-1:0]      rsp_min_column,
   output logic [SLOT_W-1:0]       rsp_entries_left,
   output logic                    rsp_status
);

   state_type           state_ff, state_in;
   logic [SIDE_W-1:0]   msize_ff;
   cmd_type             cmd_ff, cmd_in;
   logic [COORD_W-1:0]  row_ff, row_in, col_ff, col_in;
   logic [DIST_W-1:0]   dist_ff, dist_in;
   logic [SLOT_W-1:0]   count_ff, count_in;
   logic [SLOT_W-1:0]   iter_ff, iter_in;
   logic [SLOT_W-1:0]   cur_ff, cur_in;
   logic [SLOT_W-1:0]   tslot_ff, tslot_in;
   logic [DIST_W-1:0]   mdist_ff, mdist_in, tdist_ff, tdist_in;
   logic [PAIR_W-1:0]   mpair_ff, mpair_in, tpair_ff, tpair_in;
   logic                moved_ff, moved_in;
   logic                status_ff, status_in;
   slot_entry_type      root_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]   rsp_dist_ff, rsp_dist_in;
   logic [PAIR_W-1:0]   rsp_pair_ff, rsp_pair_in;
   logic [SLOT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                rsp_status_ff, rsp_status_in;

   // Memory and comparator hookup
   logic                slot_wr_en, slot_rd_en, idx_wr_en, idx_rd_en;
   logic [SLOT_W-1:0]   slot_wr_slot, rd_slot_a, rd_slot_b;
   slot_entry_type      slot_wr_data, rd_a, rd_b;
   logic [PAIR_W-1:0]   idx_wr_addr, idx_rd_addr;
   logic [SLOT_W-1:0]   idx_wr_data, idx_rd_data;
   logic [DIST_W-1:0]   cmp_a, cmp_b;
   cmp_result_type      cmp;

   // Derived geometry
   logic [SIDE_W-1:0]   side;
   logic [SLOT_W-1:0]   area, load_slot;
   logic [PAIR_W-1:0]   pair;
   logic [SLOT_W:0]     child2, count_x;
   logic                off_matrix;

   imhp_slot_ram u_slot_ram (
      .clock     (clock),
      .wr_en     (slot_wr_en),
      .wr_addr   (PAIR_W'(slot_wr_slot - SLOT_W'(1))),
      .wr_data   (slot_wr_data),
      .rd_en     (slot_rd_en),
      .rd_addr_a (PAIR_W'(rd_slot_a - SLOT_W'(1))),
      .rd_addr_b (PAIR_W'(rd_slot_b - SLOT_W'(1))),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   imhp_index_ram u_index_ram (
      .clock   (clock),
      .wr_en   (idx_wr_en),
      .wr_addr (idx_wr_addr),
      .wr_data (idx_wr_data),
      .rd_en   (idx_rd_en),
      .rd_addr (idx_rd_addr),
      .rd_data (idx_rd_data)
   );

   imhp_compare u_compare (
      .a      (cmp_a),
      .b      (cmp_b),
      .result (cmp)
   );

   // Side clamp, heap size and load slot
   always_comb begin
      if (msize_ff == '0) begin
         side = SIDE_W'(1);
      end else if (msize_ff > SIDE_RESET) begin
         side = SIDE_RESET;
      end else begin
         side = msize_ff;
      end
      area       = SLOT_W'(side) * SLOT_W'(side);
      load_slot  = SLOT_W'(row_ff) * SLOT_W'(side) + SLOT_W'(col_ff) + SLOT_W'(1);
      pair       = {row_ff, col_ff};
      off_matrix = ({1'b0, row_ff} >= side) || ({1'b0, col_ff} >= side);
      child2     = {cur_ff, 1'b0};
      count_x    = {1'b0, count_ff};
   end

   // Next state and datapath control
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      dist_in       = dist_ff;
      count_in      = count_ff;
      iter_in       = iter_ff;
      cur_in        = cur_ff;
      tslot_in      = tslot_ff;
      mdist_in      = mdist_ff;
      mpair_in      = mpair_ff;
      tdist_in      = tdist_ff;
      tpair_in      = tpair_ff;
      moved_in      = moved_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_dist_in   = rsp_dist_ff;
      rsp_pair_in   = rsp_pair_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      slot_wr_en    = 1'b0;
      slot_wr_slot  = cur_ff;
      slot_wr_data  = '{distance: mdist_ff, pair: mpair_ff};
      slot_rd_en    = 1'b0;
      rd_slot_a     = cur_ff;
      rd_slot_b     = count_ff;
      idx_wr_en     = 1'b0;
      idx_wr_addr   = mpair_ff;
      idx_wr_data   = cur_ff;
      idx_rd_en     = 1'b0;
      idx_rd_addr   = pair;
      cmp_a         = mdist_ff;
      cmp_b         = tdist_ff;
      req_ready     = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = cmd_type'(req_command);
               row_in    = req_row;
               col_in    = req_column;
               dist_in   = req_distance;
               status_in = 1'b0;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (cmd_ff == CMD_BUILD) begin
               count_in = area;
               iter_in  = area;
               state_in = ST_BUILD_NEXT;
            end else if (off_matrix) begin
               status_in = 1'b1;
               state_in  = ST_DONE;
            end else if (cmd_ff == CMD_LOAD) begin
               slot_wr_en   = 1'b1;
               slot_wr_slot = load_slot;
               slot_wr_data = '{distance: dist_ff, pair: pair};
               idx_wr_en    = 1'b1;
               idx_wr_addr  = pair;
               idx_wr_data  = load_slot;
               state_in     = ST_DONE;
            end else begin
               idx_rd_en = 1'b1;
               state_in  = ST_IDX_WAIT;
            end
         end
         ST_IDX_WAIT: begin
            if (idx_rd_data == '0 || idx_rd_data > count_ff) begin
               status_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               cur_in     = idx_rd_data;
               slot_rd_en = 1'b1;
               rd_slot_a  = idx_rd_data;
               rd_slot_b  = count_ff;
               state_in   = (cmd_ff == CMD_CHANGE) ? ST_CHG_CMP : ST_REM_W1;
            end
         end
         ST_CHG_CMP: begin
            cmp_a    = dist_ff;
            cmp_b    = rd_a.distance;
            mdist_in = dist_ff;
            mpair_in = rd_a.pair;
            moved_in = 1'b0;
            state_in = cmp.gt ? ST_SK_TEST : ST_RS_TEST;
         end
         ST_REM_W1: begin
            // Last slot takes the removed pair with infinity
            slot_wr_en   = 1'b1;
            slot_wr_slot = count_ff;
            slot_wr_data = '{distance: INFINITY, pair: rd_a.pair};
            idx_wr_en    = 1'b1;
            idx_wr_addr  = rd_b.pair;
            idx_wr_data  = cur_ff;
            tdist_in     = rd_a.distance;
            tpair_in     = rd_a.pair;
            mdist_in     = (cur_ff == count_ff) ? INFINITY : rd_b.distance;
            mpair_in     = rd_b.pair;
            state_in     = ST_REM_W2;
         end
         ST_REM_W2: begin
            idx_wr_en   = 1'b1;
            idx_wr_addr = tpair_ff;
            idx_wr_data = count_ff;
            count_in    = count_ff - SLOT_W'(1);
            moved_in    = 1'b0;
            state_in    = cmp.gt ? ST_SK_TEST : ST_RS_TEST;
         end
         ST_BUILD_NEXT: begin
            if (iter_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               slot_rd_en = 1'b1;
               rd_slot_a  = iter_ff;
               state_in   = ST_BUILD_LOAD;
            end
         end
         ST_BUILD_LOAD: begin
            mdist_in = rd_a.distance;
            mpair_in = rd_a.pair;
            cur_in   = iter_ff;
            moved_in = 1'b0;
            state_in = ST_SK_TEST;
         end
         ST_SK_TEST: begin
            if (child2 > count_x) begin
               state_in = ST_FINISH;
            end else begin
               slot_rd_en = 1'b1;
               rd_slot_a  = child2[SLOT_W-1:0];
               rd_slot_b  = child2[SLOT_W-1:0] + SLOT_W'(1);
               state_in   = ST_SK_CMP1;
            end
         end
         ST_SK_CMP1: begin
            // Left child unless right exists and is strictly smaller
            cmp_a = rd_a.distance;
            cmp_b = rd_b.distance;
            if ((child2 + (SLOT_W+1)'(1) <= count_x) && cmp.gt) begin
               tdist_in = rd_b.distance;
               tpair_in = rd_b.pair;
               tslot_in = child2[SLOT_W-1:0] + SLOT_W'(1);
            end else begin
               tdist_in = rd_a.distance;
               tpair_in = rd_a.pair;
               tslot_in = child2[SLOT_W-1:0];
            end
            state_in = ST_SK_CMP2;
         end
         ST_SK_CMP2: begin
            if (cmp.gt) begin
               slot_wr_en   = 1'b1;
               slot_wr_data = '{distance: tdist_ff, pair: tpair_ff};
               idx_wr_en    = 1'b1;
               idx_wr_addr  = tpair_ff;
               cur_in       = tslot_ff;
               moved_in     = 1'b1;
               state_in     = ST_SK_TEST;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_RS_TEST: begin
            if (cur_ff <= SLOT_W'(1)) begin
               state_in = ST_FINISH;
            end else begin
               slot_rd_en = 1'b1;
               rd_slot_a  = cur_ff >> 1;
               state_in   = ST_RS_CMP;
            end
         end
         ST_RS_CMP: begin
            cmp_b = rd_a.distance;
            if (cmp.lt) begin
               slot_wr_en   = 1'b1;
               slot_wr_data = rd_a;
               idx_wr_en    = 1'b1;
               idx_wr_addr  = rd_a.pair;
               cur_in       = cur_ff >> 1;
               moved_in     = 1'b1;
               state_in     = ST_RS_TEST;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Moving entry lands in its final slot
            slot_wr_en = 1'b1;
            idx_wr_en  = moved_ff;
            if (cmd_ff == CMD_BUILD) begin
               iter_in  = iter_ff - SLOT_W'(1);
               state_in = ST_BUILD_NEXT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = count_ff;
               rsp_status_in = status_ff;
               if (count_ff == '0) begin
                  rsp_dist_in = INFINITY;
                  rsp_pair_in = '0;
               end else begin
                  rsp_dist_in = root_ff.distance;
                  rsp_pair_in = root_ff.pair;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         msize_ff     <= SIDE_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            msize_ff <= csr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      dist_ff       <= dist_in;
      iter_ff       <= iter_in;
      cur_ff        <= cur_in;
      tslot_ff      <= tslot_in;
      mdist_ff      <= mdist_in;
      mpair_ff      <= mpair_in;
      tdist_ff      <= tdist_in;
      tpair_ff      <= tpair_in;
      moved_ff      <= moved_in;
      status_ff     <= status_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_pair_ff   <= rsp_pair_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Shadow of slot 1 for the minimum report
   always_ff @(posedge clock) begin
      if (slot_wr_en && slot_wr_slot == SLOT_W'(1)) begin
         root_ff <= slot_wr_data;
      end
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_min_distance = rsp_dist_ff;
   assign rsp_min_row      = rsp_pair_ff[PAIR_W-1 -: COORD_W];
   assign rsp_min_column   = rsp_pair_ff[COORD_W-1:0];
   assign rsp_entries_left = rsp_count_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
`default_nettype wire

// ===== hdl/imhp_compare.sv =====
// Shared unsigned distance comparator used by every sift step.
// Depends on imhp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imhp_compare
   import imhp_pkg::*;
(
   input  wire logic [DIST_W-1:0] a,
   input  wire logic [DIST_W-1:0] b,
   output cmp_result_type         result
);

   // Greater and less flags of a against b
   always_comb begin
      result.gt = (a > b);
      result.lt = (a < b);
   end

endmodule
`default_nettype wire

// ===== hdl/imhp_slot_ram.sv =====
// Heap slot memory: distance and pair per slot, one write, two registered reads.
// Depends on imhp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imhp_slot_ram
   import imhp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [PAIR_W-1:0] wr_addr,
   input  wire slot_entry_type    wr_data,
   input  wire logic              rd_en,
   input  wire logic [PAIR_W-1:0] rd_addr_a,
   input  wire logic [PAIR_W-1:0] rd_addr_b,
   output slot_entry_type         rd_data_a,
   output slot_entry_type         rd_data_b
);

   slot_entry_type mem [PAIRS];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Two read ports, data held while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/imhp_index_ram.sv =====
// Pair-to-slot index memory, one write and one registered read.
// Depends on imhp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imhp_index_ram
   import imhp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [PAIR_W-1:0] wr_addr,
   input  wire logic [SLOT_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [PAIR_W-1:0] rd_addr,
   output logic      [SLOT_W-1:0] rd_data
);

   logic [SLOT_W-1:0] mem [PAIRS];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/imhp_checker.sv =====
// Port-level checks for the indexed min-heap pairs unit, bound to the top level.
// Depends on imhp_pkg and indexed_min_heap_pairs_unit.
`timescale 1ns / 1ps
`default_nettype none
module imhp_checker
   import imhp_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [DIST_W-1:0]  rsp_min_distance,
   input wire logic [COORD_W-1:0] rsp_min_row,
   input wire logic [COORD_W-1:0] rsp_min_column,
   input wire logic [SLOT_W-1:0]  rsp_entries_left
);

   // Response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before accept");

   // Busy right after a request transaction
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // Empty heap reports infinity at pair zero
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entries_left == '0 |->
         rsp_min_distance == INFINITY && rsp_min_row == '0 && rsp_min_column == '0)
      else $error("empty heap reports a minimum");

   // Heap never exceeds the slot count
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entries_left <= SLOT_W'(PAIRS))
      else $error("entry count out of range");

   // No response out of reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind indexed_min_heap_pairs_unit imhp_checker u_imhp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_min_distance (rsp_min_distance),
   .rsp_min_row      (rsp_min_row),
   .rsp_min_column   (rsp_min_column),
   .rsp_entries_left (rsp_entries_left)
);
`default_nettype wire
